/* design/mle_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and constants for the mesh leader election block
// no dependencies

package mle_pkg;

   // depth of the per-item result buffer
   localparam int RES_MAX = 16;

   localparam logic [23:0] COLOR_LEADER = 24'h4682B4;
   localparam logic [23:0] COLOR_NONE   = 24'h76448A;
   localparam logic [15:0] CONC_RESET   = 16'd3000;
   localparam logic [15:0] CALL_RESET   = 16'd2000;

   // input operation codes
   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_LEADER = 3'd1;
   localparam logic [2:0] OP_ANNC   = 3'd2;
   localparam logic [2:0] OP_VOTE   = 3'd3;
   localparam logic [2:0] OP_CONN   = 3'd4;

   // result message kinds
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_VOTE = 2'd1;
   localparam logic [1:0] KIND_LEAD = 2'd2;
   localparam logic [1:0] KIND_CALL = 2'd3;

   // configuration register indexes
   localparam logic [1:0] REG_NODE_ID = 2'd0;
   localparam logic [1:0] REG_VOTE    = 2'd1;
   localparam logic [1:0] REG_CONC    = 2'd2;
   localparam logic [1:0] REG_CALL    = 2'd3;

   // commands from controller to datapath
   typedef struct packed {
      logic       accept;
      logic       scan_clr;
      logic       scan_vote;
      logic       scan_color;
      logic       scan_best;
      logic       scan_pick;
      logic       vote_wr;
      logic       color_wr;
      logic       best_apply;
      logic       pick_apply;
      logic       emit;
      logic [1:0] emit_kind;
      logic       out_step;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [2:0] op;
      logic       conc_fire;
      logic       call_fire;
      logic       lead_self;
      logic       scan_last;
      logic       hit;
      logic       hit_self;
      logic       pend_empty;
      logic       out_last;
   } sts_type;

   // round-robin colour palette, upper slots repeat the first four
   function automatic logic [23:0] palette_color(input logic [3:0] idx);
      logic [23:0] c;
      unique case (idx)
         4'd0:  c = 24'h8B0000;
         4'd1:  c = 24'h228B22;
         4'd2:  c = 24'hFFFF00;
         4'd3:  c = 24'hFF0000;
         4'd4:  c = 24'hFF1493;
         4'd5:  c = 24'hBDB76B;
         4'd6:  c = 24'hFF6347;
         4'd7:  c = 24'h008B8B;
         4'd8:  c = 24'hFFDAB9;
         4'd9:  c = 24'h87CEEB;
         4'd10: c = 24'hD2691E;
         4'd11: c = 24'h708090;
         4'd12: c = 24'h8B0000;
         4'd13: c = 24'h228B22;
         4'd14: c = 24'hFFFF00;
         4'd15: c = 24'hFF0000;
         default: c = 24'h8B0000;
      endcase
      return c;
   endfunction

endpackage

/* design/mle_ctrl.sv */
`timescale 1ns / 1ps
// election controller: sequences table scans, conclusion and result output
// depends on mle_pkg

module mle_ctrl import mle_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy,
   output logic    rsp_valid
);

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_DISP  = 13'b0000000000010,
      S_VSCAN = 13'b0000000000100,
      S_VWR   = 13'b0000000001000,
      S_CSCAN = 13'b0000000010000,
      S_CWR   = 13'b0000000100000,
      S_BEST  = 13'b0000001000000,
      S_BDONE = 13'b0000010000000,
      S_PICK  = 13'b0000100000000,
      S_PDONE = 13'b0001000000000,
      S_CALL  = 13'b0010000000000,
      S_FIN   = 13'b0100000000000,
      S_OUT   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      conc_ff, conc_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      conc_in  = conc_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_DISP;
            end
         end
         S_DISP: begin
            cmd.scan_clr = 1'b1;
            priority if (sts.op == OP_TICK) begin
               if (sts.conc_fire) begin
                  conc_in  = 1'b1;
                  state_in = S_BEST;
               end else begin
                  state_in = S_CALL;
               end
            end else if (sts.op == OP_ANNC || sts.op == OP_VOTE) begin
               state_in = S_VSCAN;
            end else if (sts.op == OP_CONN && sts.lead_self) begin
               state_in = S_CSCAN;
            end else begin
               state_in = S_FIN;
            end
         end
         S_VSCAN: begin
            cmd.scan_vote = 1'b1;
            if (sts.scan_last) state_in = S_VWR;
         end
         S_VWR: begin
            cmd.vote_wr = 1'b1;
            if (sts.op == OP_ANNC) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_VOTE;
            end
            state_in = S_FIN;
         end
         S_CSCAN: begin
            cmd.scan_color = 1'b1;
            if (sts.scan_last) state_in = S_CWR;
         end
         S_CWR: begin
            cmd.color_wr  = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_LEAD;
            cmd.scan_clr  = 1'b1;
            state_in      = conc_ff ? S_PICK : S_FIN;
         end
         S_BEST: begin
            cmd.scan_best = 1'b1;
            if (sts.scan_last) state_in = S_BDONE;
         end
         S_BDONE: begin
            cmd.best_apply = 1'b1;
            cmd.scan_clr   = 1'b1;
            state_in       = (sts.hit && sts.hit_self) ? S_PICK : S_CALL;
         end
         S_PICK: begin
            cmd.scan_pick = 1'b1;
            if (sts.scan_last) state_in = S_PDONE;
         end
         S_PDONE: begin
            cmd.pick_apply = 1'b1;
            cmd.scan_clr   = 1'b1;
            priority if (!sts.hit) state_in = S_CALL;
            else if (sts.hit_self) state_in = S_PICK;
            else state_in = S_CSCAN;
         end
         S_CALL: begin
            conc_in = 1'b0;
            if (sts.call_fire) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_CALL;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (sts.pend_empty) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_NONE;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            cmd.out_step = 1'b1;
            if (sts.out_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         conc_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         conc_ff  <= conc_in;
      end
   end

`ifndef ASSERT_OFF
   a_out_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> !sts.pend_empty)
      else $error("result output with empty buffer");
   a_accept_disp: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == S_IDLE) |=> state_ff == S_DISP)
      else $error("accepted item not dispatched");
   a_one_scan: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.scan_vote, cmd.scan_color, cmd.scan_best, cmd.scan_pick}))
      else $error("more than one scan active");
   a_pick_in_conc: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PICK |-> conc_ff)
      else $error("leader pick outside conclusion");
`endif

endmodule

/* design/mle_dpath.sv */
`timescale 1ns / 1ps
// election datapath: config registers, vote and colour tables, timers,
// leader state and result buffer; depends on mle_pkg

module mle_dpath import mle_pkg::*; #(
   parameter int MAX_NODES   = 16,
   parameter int COLOR_COUNT = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_from_node,
   input  logic [9:0]  req_vote_in,
   input  logic [23:0] req_color_in,
   input  logic        cfg_we,
   input  logic [1:0]  cfg_addr,
   input  logic [31:0] cfg_wdata,
   output logic [31:0] cfg_rdata,
   output logic [1:0]  rsp_send_kind,
   output logic [31:0] rsp_dest_node,
   output logic [23:0] rsp_color_out,
   output logic [9:0]  rsp_vote_out,
   output logic [31:0] rsp_leader_id,
   output logic        rsp_leader_known,
   output logic [23:0] rsp_my_color,
   output logic        rsp_table_full,
   output logic        rsp_last
);

   localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_NODES - 1);
   localparam int RW = $clog2(RES_MAX);
   localparam logic [4:0] CC_LIMIT = 5'(COLOR_COUNT);

   // configuration
   logic [31:0] my_id_ff;
   logic [9:0]  my_vote_ff;
   logic [15:0] conc_dly_ff, call_dly_ff;

   // tables
   logic        vok_ff [MAX_NODES];
   logic [31:0] vid_ff [MAX_NODES];
   logic [9:0]  vval_ff[MAX_NODES];
   logic        cok_ff [MAX_NODES];
   logic [31:0] cid_ff [MAX_NODES];
   logic [23:0] cval_ff[MAX_NODES];

   // item and election state
   logic [2:0]  op_ff;
   logic [31:0] key_ff, key_in;
   logic [9:0]  kval_ff;
   logic        conc_fire_ff, call_fire_ff;
   logic [3:0]  next_ff, next_in;
   logic [31:0] leader_ff, leader_in;
   logic        lvalid_ff, lvalid_in;
   logic [23:0] color_ff, color_in;
   logic [15:0] conc_cnt_ff, conc_cnt_in;
   logic [15:0] call_cnt_ff, call_cnt_in;
   logic        full_ff, full_in;
   logic [31:0] prev_ff, prev_in;
   logic        hprev_ff, hprev_in;

   // scan trackers
   logic [IW-1:0] idx_ff, idx_in;
   logic          hit_ff, hit_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic [31:0]   hit_id_ff, hit_id_in;
   logic [23:0]   hit_val_ff, hit_val_in;
   logic          free_ff, free_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;

   // result buffer
   logic [1:0]    pk_ff[RES_MAX];
   logic [31:0]   pd_ff[RES_MAX];
   logic [23:0]   pc_ff[RES_MAX];
   logic [RW:0]   pend_n_ff, pend_n_in;
   logic [RW-1:0] out_idx_ff, out_idx_in;

   logic        lead_self;
   logic [23:0] new_color;
   logic [4:0]  next_inc;
   logic [15:0] conc_load, call_load;
   logic        e_vok;
   logic [31:0] e_vid;
   logic [9:0]  e_vval;
   logic        e_cok;
   logic [31:0] e_cid;
   logic [23:0] e_cval;

   assign lead_self = lvalid_ff && (leader_ff == my_id_ff);
   assign new_color = hit_ff ? hit_val_ff : palette_color(next_ff);
   assign next_inc  = {1'b0, next_ff} + 5'd1;
   assign conc_load = (conc_dly_ff == 16'd0) ? 16'd1 : conc_dly_ff;
   assign call_load = (call_dly_ff == 16'd0) ? 16'd1 : call_dly_ff;

   // entry under scan
   assign e_vok  = vok_ff[idx_ff];
   assign e_vid  = vid_ff[idx_ff];
   assign e_vval = vval_ff[idx_ff];
   assign e_cok  = cok_ff[idx_ff];
   assign e_cid  = cid_ff[idx_ff];
   assign e_cval = cval_ff[idx_ff];

   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         my_id_ff    <= '0;
         my_vote_ff  <= '0;
         conc_dly_ff <= CONC_RESET;
         call_dly_ff <= CALL_RESET;
      end else if (cfg_we) begin
         unique case (cfg_addr)
            REG_NODE_ID: my_id_ff    <= cfg_wdata;
            REG_VOTE:    my_vote_ff  <= cfg_wdata[9:0];
            REG_CONC:    conc_dly_ff <= cfg_wdata[15:0];
            REG_CALL:    call_dly_ff <= cfg_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_addr)
         REG_NODE_ID: cfg_rdata = my_id_ff;
         REG_VOTE:    cfg_rdata = {22'd0, my_vote_ff};
         REG_CONC:    cfg_rdata = {16'd0, conc_dly_ff};
         REG_CALL:    cfg_rdata = {16'd0, call_dly_ff};
         default:     cfg_rdata = '0;
      endcase
   end

   // scan step: one table entry per cycle
   always_comb begin
      idx_in      = idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_id_in   = hit_id_ff;
      hit_val_in  = hit_val_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (cmd.scan_clr) begin
         idx_in  = '0;
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (cmd.scan_vote || cmd.scan_color || cmd.scan_best || cmd.scan_pick) begin
         idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
         if (cmd.scan_vote) begin
            if (e_vok && e_vid == key_ff && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = idx_ff;
            end
            if (!e_vok && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
         end
         if (cmd.scan_color) begin
            if (e_cok && e_cid == key_ff && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = idx_ff;
               hit_val_in = e_cval;
            end
            if (!e_cok && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
         end
         if (cmd.scan_best) begin
            if (e_vok && (!hit_ff || e_vval > hit_val_ff[9:0] ||
                (e_vval == hit_val_ff[9:0] && e_vid < hit_id_ff))) begin
               hit_in     = 1'b1;
               hit_id_in  = e_vid;
               hit_val_in = {14'd0, e_vval};
            end
         end
         if (cmd.scan_pick) begin
            if (e_vok && (!hprev_ff || e_vid > prev_ff) && (!hit_ff || e_vid < hit_id_ff)) begin
               hit_in    = 1'b1;
               hit_id_in = e_vid;
            end
         end
      end
   end

   // leader, timers, colour index and item state
   always_comb begin
      key_in      = key_ff;
      next_in     = next_ff;
      leader_in   = leader_ff;
      lvalid_in   = lvalid_ff;
      color_in    = color_ff;
      conc_cnt_in = conc_cnt_ff;
      call_cnt_in = call_cnt_ff;
      full_in     = full_ff;
      prev_in     = prev_ff;
      hprev_in    = hprev_ff;
      if (cmd.accept) begin
         full_in = 1'b0;
         key_in  = (req_op == OP_ANNC) ? my_id_ff : req_from_node;
         priority if (req_op == OP_TICK) begin
            if (conc_cnt_ff != 16'd0) conc_cnt_in = conc_cnt_ff - 16'd1;
            if (call_cnt_ff != 16'd0) call_cnt_in = call_cnt_ff - 16'd1;
         end else if (req_op == OP_LEADER) begin
            call_cnt_in = '0;
            leader_in   = req_from_node;
            lvalid_in   = 1'b1;
            color_in    = req_color_in;
         end else if (req_op == OP_VOTE) begin
            conc_cnt_in = conc_load;
         end else if (req_op == OP_CONN && !lead_self) begin
            call_cnt_in = call_load;
         end
      end
      if (cmd.vote_wr && !hit_ff && !free_ff) full_in = 1'b1;
      if (cmd.color_wr && !hit_ff) begin
         next_in = (next_inc >= CC_LIMIT) ? 4'd0 : next_inc[3:0];
         if (!free_ff) full_in = 1'b1;
      end
      if (cmd.best_apply) begin
         hprev_in = 1'b0;
         if (hit_ff) begin
            leader_in = hit_id_ff;
            lvalid_in = 1'b1;
            color_in  = COLOR_LEADER;
         end else begin
            leader_in = '0;
            lvalid_in = 1'b0;
         end
      end
      if (cmd.pick_apply) begin
         prev_in  = hit_id_ff;
         hprev_in = 1'b1;
         key_in   = hit_id_ff;
      end
   end

   // result buffer pointers
   always_comb begin
      pend_n_in  = pend_n_ff;
      out_idx_in = out_idx_ff;
      if (cmd.accept) begin
         pend_n_in  = '0;
         out_idx_in = '0;
      end
      if (cmd.emit && pend_n_ff < (RW+1)'(RES_MAX)) pend_n_in = pend_n_ff + 1'b1;
      if (cmd.out_step) out_idx_in = out_idx_ff + 1'b1;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff     <= '0;
         leader_ff   <= '0;
         lvalid_ff   <= 1'b0;
         color_ff    <= COLOR_NONE;
         conc_cnt_ff <= '0;
         call_cnt_ff <= '0;
         full_ff     <= 1'b0;
         hprev_ff    <= 1'b0;
         idx_ff      <= '0;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
         pend_n_ff   <= '0;
         out_idx_ff  <= '0;
      end else begin
         next_ff     <= next_in;
         leader_ff   <= leader_in;
         lvalid_ff   <= lvalid_in;
         color_ff    <= color_in;
         conc_cnt_ff <= conc_cnt_in;
         call_cnt_ff <= call_cnt_in;
         full_ff     <= full_in;
         hprev_ff    <= hprev_in;
         idx_ff      <= idx_in;
         hit_ff      <= hit_in;
         free_ff     <= free_in;
         pend_n_ff   <= pend_n_in;
         out_idx_ff  <= out_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      prev_ff     <= prev_in;
      hit_idx_ff  <= hit_idx_in;
      hit_id_ff   <= hit_id_in;
      hit_val_ff  <= hit_val_in;
      free_idx_ff <= free_idx_in;
      if (cmd.accept) begin
         op_ff        <= req_op;
         kval_ff      <= (req_op == OP_ANNC) ? my_vote_ff : req_vote_in;
         conc_fire_ff <= (req_op == OP_TICK) && (conc_cnt_ff == 16'd1);
         call_fire_ff <= (req_op == OP_TICK) && (call_cnt_ff == 16'd1);
      end
   end

   // table valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_NODES; i++) begin
            vok_ff[i] <= 1'b0;
            cok_ff[i] <= 1'b0;
         end
      end else begin
         if (cmd.accept && req_op == OP_ANNC) begin
            for (int i = 0; i < MAX_NODES; i++) vok_ff[i] <= 1'b0;
         end
         if (cmd.vote_wr && !hit_ff && free_ff) vok_ff[free_idx_ff] <= 1'b1;
         if (cmd.color_wr && !hit_ff && free_ff) cok_ff[free_idx_ff] <= 1'b1;
      end
   end

   // table payload
   always_ff @(posedge clock) begin
      if (cmd.vote_wr) begin
         if (hit_ff) begin
            vval_ff[hit_idx_ff] <= kval_ff;
         end else if (free_ff) begin
            vid_ff[free_idx_ff]  <= key_ff;
            vval_ff[free_idx_ff] <= kval_ff;
         end
      end
      if (cmd.color_wr && !hit_ff && free_ff) begin
         cid_ff[free_idx_ff]  <= key_ff;
         cval_ff[free_idx_ff] <= new_color;
      end
   end

   // result buffer write
   always_ff @(posedge clock) begin
      if (cmd.emit && pend_n_ff < (RW+1)'(RES_MAX)) begin
         pk_ff[pend_n_ff[RW-1:0]] <= cmd.emit_kind;
         pd_ff[pend_n_ff[RW-1:0]] <= (cmd.emit_kind == KIND_LEAD) ? key_ff : 32'd0;
         pc_ff[pend_n_ff[RW-1:0]] <= (cmd.emit_kind == KIND_LEAD) ? new_color : 24'd0;
      end
   end

   // status to controller
   assign sts.op         = op_ff;
   assign sts.conc_fire  = conc_fire_ff;
   assign sts.call_fire  = call_fire_ff;
   assign sts.lead_self  = lead_self;
   assign sts.scan_last  = (idx_ff == LAST_IDX);
   assign sts.hit        = hit_ff;
   assign sts.hit_self   = (hit_id_ff == my_id_ff);
   assign sts.pend_empty = (pend_n_ff == '0);
   assign sts.out_last   = ({1'b0, out_idx_ff} + 1'b1) == pend_n_ff;

   // result fields
   assign rsp_send_kind    = pk_ff[out_idx_ff];
   assign rsp_dest_node    = pd_ff[out_idx_ff];
   assign rsp_color_out    = pc_ff[out_idx_ff];
   assign rsp_vote_out     = (pk_ff[out_idx_ff] == KIND_VOTE) ? my_vote_ff : 10'd0;
   assign rsp_leader_id    = leader_ff;
   assign rsp_leader_known = lvalid_ff;
   assign rsp_my_color     = color_ff;
   assign rsp_table_full   = full_ff;
   assign rsp_last         = sts.out_last;

`ifndef ASSERT_OFF
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_n_ff <= (RW+1)'(RES_MAX))
      else $error("result buffer overrun");
   a_full_reason: assert property (@(posedge clock) disable iff (reset)
      (cmd.vote_wr && !hit_ff && !free_ff) |=> full_ff)
      else $error("dropped vote entry not flagged");
   a_best_leader: assert property (@(posedge clock) disable iff (reset)
      (cmd.best_apply && hit_ff) |=> (lvalid_ff && color_ff == COLOR_LEADER))
      else $error("conclusion did not set leader");
`endif

endmodule

/* design/mesh_leader_election_core.sv */
`timescale 1ns / 1ps
// top level of the mesh leader election block
// depends on mle_pkg, mle_ctrl and mle_dpath
//
// Usage: drive req_op, req_from_node, req_vote_in and req_color_in and raise
// start; the item is taken at a clock edge where start is high and busy low.
// Each item gives one or more results, one per cycle on consecutive cycles,
// each marked by rsp_valid; rsp_last flags the final one. The receiver takes
// every result in its cycle and cannot hold results off. Status fields
// (leader, colour, table_full) reflect the whole item.
// After the accepting edge, a leader announce, a new connection as follower
// or an undefined op passes the dispatch and finish states before its first
// result; a tick that does not conclude also passes the callout state. A vote
// or vote announce walks the vote table, one entry a cycle. A new connection
// on the leader walks the colour table the same way. A tick that concludes
// walks the vote table once for the winner; on the leader with V voters it
// walks the vote table V + 1 more times and the colour table V - 1 times.
// Busy stays high until the last result has been shown, and table walking
// sets the rate at which items are taken.
// Reset (synchronous, active high) empties both tables, clears the leader,
// stops both timers and restores the configuration defaults.
// The user is to write the configuration over the APB port only while busy
// is low; the block itself does not enforce this.

module mesh_leader_election_core import mle_pkg::*; #(
   parameter int MAX_NODES   = 16,
   parameter int COLOR_COUNT = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_from_node,
   input  logic [9:0]  req_vote_in,
   input  logic [23:0] req_color_in,
   output logic        rsp_valid,
   output logic [1:0]  rsp_send_kind,
   output logic [31:0] rsp_dest_node,
   output logic [23:0] rsp_color_out,
   output logic [9:0]  rsp_vote_out,
   output logic [31:0] rsp_leader_id,
   output logic        rsp_leader_known,
   output logic [23:0] rsp_my_color,
   output logic        rsp_table_full,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cmd_type cmd;
   sts_type sts;
   logic    cfg_we;

   // register write on the access phase
   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite;

   mle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   mle_dpath #(
      .MAX_NODES   (MAX_NODES),
      .COLOR_COUNT (COLOR_COUNT)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_op           (req_op),
      .req_from_node    (req_from_node),
      .req_vote_in      (req_vote_in),
      .req_color_in     (req_color_in),
      .cfg_we           (cfg_we),
      .cfg_addr         (paddr[3:2]),
      .cfg_wdata        (pwdata),
      .cfg_rdata        (prdata),
      .rsp_send_kind    (rsp_send_kind),
      .rsp_dest_node    (rsp_dest_node),
      .rsp_color_out    (rsp_color_out),
      .rsp_vote_out     (rsp_vote_out),
      .rsp_leader_id    (rsp_leader_id),
      .rsp_leader_known (rsp_leader_known),
      .rsp_my_color     (rsp_my_color),
      .rsp_table_full   (rsp_table_full),
      .rsp_last         (rsp_last)
   );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for mesh_leader_election_core
// depends on mle_pkg and the core rtl; predicts each item's results and checks them in order

module tb;
   import mle_pkg::*;

   // one expected or observed result
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] dest;
      logic [23:0] colour;
      logic [9:0]  vote;
      logic [31:0] leader;
      logic        known;
      logic [23:0] own_colour;
      logic        full;
      logic        last;
   } election_msg_t;

   localparam int NODES   = 16;
   localparam int HUES    = 12;
   localparam logic [2:0] OP_UNDEF = 3'd7;

   // election predictor and store of expected messages
   class election_scoreboard;
      logic [31:0] node_id;
      logic [9:0]  own_vote;
      logic [15:0] conc_delay, call_delay;
      logic [31:0] vote_id [NODES];
      logic [9:0]  vote_val [NODES];
      bit          vote_ok [NODES];
      logic [31:0] hue_id [NODES];
      logic [23:0] hue_val [NODES];
      bit          hue_ok [NODES];
      logic [23:0] hues [HUES];
      logic [3:0]  next_hue;
      logic [31:0] leader;
      bit          known;
      logic [23:0] colour;
      logic [15:0] conc_cnt, call_cnt;
      bit          full;
      election_msg_t pend [$];
      election_msg_t expected [$];
      int          errors, checked, items, full_seen, lead_msgs;

      function new();
         hues = '{24'h8B0000, 24'h228B22, 24'hFFFF00, 24'hFF0000, 24'hFF1493, 24'hBDB76B,
                  24'hFF6347, 24'h008B8B, 24'hFFDAB9, 24'h87CEEB, 24'hD2691E, 24'h708090};
         node_id = '0; own_vote = '0; conc_delay = CONC_RESET; call_delay = CALL_RESET;
         foreach (vote_ok[i]) begin
            vote_ok[i] = 0; hue_ok[i] = 0;
         end
         next_hue = '0; leader = '0; known = 0; colour = COLOR_NONE;
         conc_cnt = '0; call_cnt = '0;
         errors = 0; checked = 0; items = 0; full_seen = 0; lead_msgs = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            REG_NODE_ID: node_id = val;
            REG_VOTE:    own_vote = val[9:0];
            REG_CONC:    conc_delay = val[15:0];
            REG_CALL:    call_delay = val[15:0];
            default: ;
         endcase
      endfunction

      function void push(logic [1:0] k, logic [31:0] d, logic [23:0] c, logic [9:0] v);
         election_msg_t m;
         if (pend.size() >= RES_MAX) return;
         m = '0;
         m.kind = k; m.dest = d; m.colour = c; m.vote = v;
         pend.push_back(m);
      endfunction

      function void store_vote(logic [31:0] id, logic [9:0] v);
         for (int i = 0; i < NODES; i++)
            if (vote_ok[i] && vote_id[i] == id) begin
               vote_val[i] = v;
               return;
            end
         for (int i = 0; i < NODES; i++)
            if (!vote_ok[i]) begin
               vote_ok[i] = 1; vote_id[i] = id; vote_val[i] = v;
               return;
            end
         full = 1;
      endfunction

      function logic [23:0] colour_for(logic [31:0] id);
         logic [23:0] c;
         for (int i = 0; i < NODES; i++)
            if (hue_ok[i] && hue_id[i] == id) return hue_val[i];
         c = hues[next_hue % HUES];
         next_hue = (next_hue + 1 >= HUES) ? 4'd0 : next_hue + 4'd1;
         for (int i = 0; i < NODES; i++)
            if (!hue_ok[i]) begin
               hue_ok[i] = 1; hue_id[i] = id; hue_val[i] = c;
               return c;
            end
         full = 1;
         return c;
      endfunction

      // highest vote wins, lowest id breaks ties; the winner hands out colours
      function void conclude();
         int best, pick;
         logic [31:0] prev;
         bit have_prev;
         best = -1; have_prev = 0; prev = '0;
         for (int i = 0; i < NODES; i++) begin
            if (!vote_ok[i]) continue;
            if (best < 0 || vote_val[i] > vote_val[best] ||
                (vote_val[i] == vote_val[best] && vote_id[i] < vote_id[best]))
               best = i;
         end
         if (best < 0) begin
            known = 0; leader = '0;
            return;
         end
         leader = vote_id[best]; known = 1; colour = COLOR_LEADER;
         if (leader != node_id) return;
         forever begin
            pick = -1;
            for (int i = 0; i < NODES; i++) begin
               if (!vote_ok[i]) continue;
               if (have_prev && vote_id[i] <= prev) continue;
               if (pick < 0 || vote_id[i] < vote_id[pick]) pick = i;
            end
            if (pick < 0) break;
            prev = vote_id[pick]; have_prev = 1;
            if (prev != node_id) push(KIND_LEAD, prev, colour_for(prev), '0);
         end
      endfunction

      // accepted item: update state and queue its messages
      function void note_item(logic [2:0] op, logic [31:0] from, logic [9:0] vin,
                              logic [23:0] cin);
         full = 0;
         pend.delete();
         if (op <= OP_CONN) items++;
         case (op)
            OP_TICK: begin
               if (conc_cnt != 0) begin
                  conc_cnt--;
                  if (conc_cnt == 0) conclude();
               end
               if (call_cnt != 0) begin
                  call_cnt--;
                  if (call_cnt == 0) push(KIND_CALL, '0, '0, '0);
               end
            end
            OP_LEADER: begin
               call_cnt = '0; leader = from; known = 1; colour = cin;
            end
            OP_ANNC: begin
               foreach (vote_ok[i]) vote_ok[i] = 0;
               store_vote(node_id, own_vote);
               push(KIND_VOTE, '0, '0, own_vote);
            end
            OP_VOTE: begin
               store_vote(from, vin);
               conc_cnt = (conc_delay != 0) ? conc_delay : 16'd1;
            end
            OP_CONN: begin
               if (known && leader == node_id) push(KIND_LEAD, from, colour_for(from), '0);
               else call_cnt = (call_delay != 0) ? call_delay : 16'd1;
            end
            default: ;
         endcase
         if (pend.size() == 0) push(KIND_NONE, '0, '0, '0);
         if (full) full_seen++;
         foreach (pend[k]) begin
            pend[k].leader = leader; pend[k].known = known;
            pend[k].own_colour = colour; pend[k].full = full;
            pend[k].last = (k == pend.size() - 1);
            if (pend[k].kind == KIND_LEAD) lead_msgs++;
            expected.push_back(pend[k]);
         end
      endfunction

      function void report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("MISMATCH %0t: %s got %h want %h", $time, what, got, want);
      endfunction

      function void check(election_msg_t got);
         election_msg_t w;
         checked++;
         if (expected.size() == 0) begin
            report("unexpected result, kind", got.kind, '0);
            return;
         end
         w = expected.pop_front();
         if (got.kind != w.kind) report("send_kind", got.kind, w.kind);
         if (got.dest != w.dest) report("dest_node", got.dest, w.dest);
         if (got.colour != w.colour) report("color_out", got.colour, w.colour);
         if (got.vote != w.vote) report("vote_out", got.vote, w.vote);
         if (got.leader != w.leader) report("leader_id", got.leader, w.leader);
         if (got.known != w.known) report("leader_known", got.known, w.known);
         if (got.own_colour != w.own_colour) report("my_color", got.own_colour, w.own_colour);
         if (got.full != w.full) report("table_full", got.full, w.full);
         if (got.last != w.last) report("last", got.last, w.last);
      endfunction
   endclass

   logic        clock, reset, start, busy;
   logic [2:0]  req_op;
   logic [31:0] req_from_node;
   logic [9:0]  req_vote_in;
   logic [23:0] req_color_in;
   logic        rsp_valid, rsp_leader_known, rsp_table_full, rsp_last;
   logic [1:0]  rsp_send_kind;
   logic [31:0] rsp_dest_node, rsp_leader_id;
   logic [23:0] rsp_color_out, rsp_my_color;
   logic [9:0]  rsp_vote_out;
   logic        psel, penable, pwrite, pready;
   logic [3:0]  paddr;
   logic [31:0] pwdata, prdata;

   election_scoreboard sb;
   logic [31:0] id_pool [24];
   bit          quiet_tail;

   mesh_leader_election_core dut (.*);

   // clock
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #40ms;
      $display("timeout waiting for results");
      $display("Verification failed");
      $finish;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check({rsp_send_kind, rsp_dest_node, rsp_color_out, rsp_vote_out, rsp_leader_id,
                   rsp_leader_known, rsp_my_color, rsp_table_full, rsp_last});
   end

   // one item, returns in the step of the accepting edge
   task automatic send_item(logic [2:0] op, logic [31:0] from, logic [9:0] vin,
                            logic [23:0] cin);
      start <= 1; req_op <= op; req_from_node <= from;
      req_vote_in <= vin; req_color_in <= cin;
      do @(posedge clock); while (busy);
      sb.note_item(op, from, vin, cin);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // wait until every expected item result has come and the block is quiet
   task automatic drain();
      start <= 0;
      do @(posedge clock); while (sb.expected.size() != 0 || busy);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel <= 0; penable <= 0; pwrite <= 0;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic configure(logic [31:0] id, logic [9:0] v, logic [15:0] cd, logic [15:0] kd);
      drain();
      csr_write(REG_NODE_ID, id);
      csr_write(REG_VOTE, {22'd0, v});
      csr_write(REG_CONC, {16'd0, cd});
      csr_write(REG_CALL, {16'd0, kd});
   endtask

   // tick until both timers have fired
   task automatic tick_out();
      while (sb.conc_cnt != 0 || sb.call_cnt != 0)
         send_item(OP_TICK, $urandom, 10'($urandom), 24'($urandom));
   endtask

   function automatic logic [15:0] pick_delay();
      case ($urandom_range(0, 4))
         0: return 16'd0;
         1: return 16'd1;
         default: return 16'($urandom_range(2, 6));
      endcase
   endfunction

   initial begin
      logic [31:0] me;
      int phase;
      sb = new();
      quiet_tail = 0;
      reset = 1; start = 0; req_op = OP_TICK; req_from_node = '0; req_vote_in = '0;
      req_color_in = '0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      foreach (id_pool[i]) id_pool[i] = $urandom;
      id_pool[0] = 32'h0; id_pool[1] = 32'hFFFF_FFFF;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, zero delays, tie break, callout, follower and leader roles
      configure(32'hFFFF_FFFF, 10'd1023, 16'd0, 16'd0);
      send_item(OP_TICK, '0, '0, '0);
      send_item(OP_UNDEF, 32'hFFFF_FFFF, 10'h3FF, 24'hFFFFFF);
      send_item(OP_ANNC, '0, '0, '0);
      send_item(OP_VOTE, 32'h0, 10'd0, 24'h0);
      send_item(OP_VOTE, 32'h1234_5678, 10'd1023, 24'h0);
      send_item(OP_TICK, '0, '0, '0);
      send_item(OP_CONN, 32'h5, '0, '0);
      send_item(OP_TICK, '0, '0, '0);
      send_item(OP_LEADER, 32'hFFFF_FFFF, 10'h3FF, 24'hFFFFFF);
      send_item(OP_CONN, 32'hA5A5_5A5A, '0, '0);
      send_item(OP_CONN, 32'hA5A5_5A5A, '0, '0);
      send_item(OP_ANNC, '0, '0, '0);
      send_item(OP_VOTE, 32'h0, 10'd1022, '0);
      send_item(OP_VOTE, 32'h7, 10'd3, '0);
      send_item(OP_VOTE, 32'hA5A5_5A5A, 10'd0, '0);
      send_item(OP_TICK, '0, '0, '0);
      send_item(OP_LEADER, 32'h0, '0, 24'h0);
      configure(32'h0, 10'd0, 16'd1, 16'd1);
      send_item(OP_ANNC, '0, '0, '0);
      send_item(OP_VOTE, 32'h9, 10'd0, '0);
      send_item(OP_TICK, '0, '0, '0);
      send_item(OP_CONN, 32'h33, '0, '0);
      // slow delays are only configured; no item here starts a timer with them
      configure(32'h0, 10'd512, 16'd65535, 16'd65535);
      send_item(OP_CONN, 32'h44, '0, '0);
      send_item(OP_TICK, '0, '0, '0);
      send_item(OP_LEADER, 32'h8000_0001, '0, 24'h800001);

      // random phases of well-formed elections with noise
      phase = 0;
      while (sb.items < 290) begin
         phase++;
         me = ($urandom_range(0, 2) == 0) ? $urandom : id_pool[$urandom_range(0, 23)];
         configure(me, ($urandom_range(0, 3) == 0) ? 10'd1023 : 10'($urandom),
                   pick_delay(), pick_delay());
         if (sb.items > 250) quiet_tail = 1;
         repeat ($urandom_range(1, 3)) begin
            send_item(OP_ANNC, $urandom, 10'($urandom), 24'($urandom));
            repeat ($urandom_range(1, 20)) begin
               if ($urandom_range(0, 6) == 0)
                  send_item(3'($urandom_range(0, 7)), $urandom, 10'($urandom),
                            24'($urandom));
               else
                  send_item(OP_VOTE, ($urandom_range(0, 9) == 0) ? me :
                            id_pool[$urandom_range(0, 23)], 10'($urandom), 24'($urandom));
            end
            tick_out();
            repeat ($urandom_range(0, 4))
               send_item(OP_CONN, ($urandom_range(0, 1)) ? $urandom :
                         id_pool[$urandom_range(0, 23)], 10'($urandom), 24'($urandom));
            if ($urandom_range(0, 4) == 0)
               send_item(OP_LEADER, $urandom, 10'($urandom), 24'($urandom));
            tick_out();
         end
         // hold the sender until everything is out
         if (phase == 3) drain();
      end

      drain();
      $display("covered %0d items, %0d results, %0d colour hand-outs, %0d table-full steps",
               sb.items, sb.checked, sb.lead_msgs, sb.full_seen);
      if (sb.errors == 0 && sb.expected.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors, sb.expected.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule
